@@ rtl/cfb_pkg.sv @@
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants for the command frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned LenW  = 16;

    localparam logic [ByteW-1:0] SYNC_FIRST  = 8'h00;
    localparam logic [ByteW-1:0] SYNC_SECOND = 8'hAA;

    // one input item as held in the input stage
    typedef struct packed {
        logic             frame_start;
        logic [ByteW-1:0] command_code;
        logic [LenW-1:0]  payload_length;
        logic             has_byte;
        logic [ByteW-1:0] payload_byte;
        logic             frame_last;
    } t_item;

    // byte of the frame that the builder sends next
    typedef enum logic [2:0] {
        PH_NONE,
        PH_SYNC0,
        PH_SYNC1,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_OPCODE,
        PH_DATA,
        PH_CSUM
    } t_phase;

endpackage

@@ rtl/cfb_in_stage.sv @@
// ----------------------------------------------------------------------------
// cfb_in_stage
// Input register: holds one item until the builder has sent all its bytes.
// ----------------------------------------------------------------------------
module cfb_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cfb_pkg::t_item i_item,
    input  logic          i_pop,
    output logic          o_head_valid,
    output cfb_pkg::t_item o_head
);
    import cfb_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready      = !r_valid || i_pop;
    assign o_head_valid = r_valid;
    assign o_head       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/cfb_builder.sv @@
// ----------------------------------------------------------------------------
// cfb_builder
// Byte sequencer with running checksum and output register.
// ----------------------------------------------------------------------------
module cfb_builder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  cfb_pkg::t_item i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last
);
    import cfb_pkg::*;

    logic             r_in_frame;
    logic [ByteW-1:0] r_sum;
    logic             r_fresh;
    t_phase           r_ph;
    logic             r_out_valid;
    logic [ByteW-1:0] r_out_byte;
    logic             r_out_last;

    t_phase           first_ph;
    t_phase           cur_ph;
    t_phase           n_ph;
    logic             can_emit;
    logic [LenW-1:0]  frame_len;
    logic [ByteW-1:0] emit_byte;
    logic [ByteW-1:0] n_sum;
    logic             n_in_frame;

    assign frame_len = i_head.payload_length + LenW'(1);

    // next-state logic
    always_comb begin
        priority if (i_head.frame_start) begin
            first_ph = PH_SYNC0;
        end else if (r_in_frame && i_head.has_byte) begin
            first_ph = PH_DATA;
        end else if (r_in_frame && i_head.frame_last) begin
            first_ph = PH_CSUM;
        end else begin
            first_ph = PH_NONE;
        end
        cur_ph = r_fresh ? first_ph : r_ph;

        unique case (cur_ph)
            PH_SYNC0:  n_ph = PH_SYNC1;
            PH_SYNC1:  n_ph = PH_LEN_HI;
            PH_LEN_HI: n_ph = PH_LEN_LO;
            PH_LEN_LO: n_ph = PH_OPCODE;
            PH_OPCODE: n_ph = i_head.has_byte ? PH_DATA :
                              (i_head.frame_last ? PH_CSUM : PH_NONE);
            PH_DATA:   n_ph = i_head.frame_last ? PH_CSUM : PH_NONE;
            default:   n_ph = PH_NONE;
        endcase
    end

    assign can_emit = i_head_valid && (cur_ph != PH_NONE) && (!r_out_valid || i_ready);
    assign o_pop    = i_head_valid && ((cur_ph == PH_NONE) || (can_emit && n_ph == PH_NONE));

    // output and checksum logic
    always_comb begin
        n_sum      = r_sum;
        n_in_frame = r_in_frame;
        unique case (cur_ph)
            PH_SYNC0: begin
                emit_byte  = SYNC_FIRST;
                n_in_frame = 1'b1;
            end
            PH_SYNC1:  emit_byte = SYNC_SECOND;
            PH_LEN_HI: begin
                emit_byte = frame_len[LenW-1:ByteW];
                n_sum     = frame_len[LenW-1:ByteW];
            end
            PH_LEN_LO: begin
                emit_byte = frame_len[ByteW-1:0];
                n_sum     = r_sum + frame_len[ByteW-1:0];
            end
            PH_OPCODE: begin
                emit_byte = i_head.command_code;
                n_sum     = r_sum + i_head.command_code;
            end
            PH_DATA: begin
                emit_byte = i_head.payload_byte;
                n_sum     = r_sum + i_head.payload_byte;
            end
            PH_CSUM: begin
                emit_byte  = ByteW'(~r_sum) + ByteW'(1);
                n_sum      = '0;
                n_in_frame = 1'b0;
            end
            default:   emit_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_sum       <= '0;
            r_fresh     <= 1'b1;
            r_ph        <= PH_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (can_emit) begin
                r_in_frame <= n_in_frame;
                r_sum      <= n_sum;
            end
            if (o_pop) begin
                r_fresh <= 1'b1;
                r_ph    <= PH_NONE;
            end else if (can_emit) begin
                r_fresh <= 1'b0;
                r_ph    <= n_ph;
            end
            if (can_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= (cur_ph == PH_CSUM);
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

`ifndef SYNTH
    a_csum_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (can_emit && cur_ph == PH_CSUM) |=> (!r_in_frame && r_sum == '0 && r_out_last))
        else $error("checksum did not close the frame");
    a_sync_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (can_emit && cur_ph == PH_SYNC0) |=> (r_in_frame && !r_fresh && r_ph == PH_SYNC1))
        else $error("header did not open a frame");
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop without a held item");
    a_mid_item_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && !r_fresh) |-> (r_ph != PH_NONE))
        else $error("item in progress with nothing left to send");
`endif

endmodule

@@ rtl/command_frame_builder_top.sv @@
// ----------------------------------------------------------------------------
// command_frame_builder_top
// Length-prefixed command framer with two's complement checksum.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register; its bytes leave
//   through the output register.
// Throughput: one output byte per cycle while the output is ready; a payload
//   item emits up to 2 bytes, a header item 5 to 7. Items with no bytes are
//   dropped; the next item can be accepted as an item's last byte is sent.
// Reset: synchronous, active low; clears the open frame and the checksum.
module command_frame_builder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // command_code, payload_length, payload_byte
    input  logic [1:0]  i_s_axis_tuser,  // frame_start, has_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // out_byte
    output logic        o_m_axis_tlast
);
    import cfb_pkg::*;

    t_item in_item;
    t_item head;
    logic  head_valid;
    logic  pop;

    assign in_item.frame_start    = i_s_axis_tuser[0];
    assign in_item.command_code   = i_s_axis_tdata[7:0];
    assign in_item.payload_length = i_s_axis_tdata[23:8];
    assign in_item.has_byte       = i_s_axis_tuser[1];
    assign in_item.payload_byte   = i_s_axis_tdata[31:24];
    assign in_item.frame_last     = i_s_axis_tlast;

    cfb_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_item       (in_item),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    cfb_builder u_builder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Streams command items into the frame builder: a short directed set, then
// random frames, some malformed, and noise, under four idle and stall modes.
// Every output byte is checked against a predicted frame byte stream.
// ----------------------------------------------------------------------------
module testbench;

    import cfb_pkg::*;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        t_item      item;
        t_idle_mode mode;
    } t_stim;

    typedef struct {
        logic [ByteW-1:0] value;
        logic             frame_end;
    } t_frame_byte;

    localparam int unsigned IdlePct      = 70;
    localparam int unsigned LightIdlePct = 9;
    localparam int unsigned RandItems    = 420;
    localparam int unsigned WatchdogMax  = 3000;
    localparam int unsigned MaxReported  = 10;
    localparam int unsigned DrainCycles  = 20;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_tdata = '0;   // command_code, payload_length, payload_byte
    logic [1:0]  s_tuser = '0;   // frame_start, has_byte
    logic        s_tlast = 1'b0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;  // out_byte
    logic        o_m_axis_tlast;

    t_stim       item_q[$];
    t_frame_byte frame_bytes_q[$];
    t_item       cur_item;
    int unsigned rx_stall_pct = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned quiet_cycles = 0;

    // predictor state
    logic [ByteW-1:0] sum_acc = '0;
    logic             frame_open = 1'b0;

    command_frame_builder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    task automatic push_frame_byte(input logic [ByteW-1:0] value, input logic is_end);
        t_frame_byte fb;
        fb.value     = value;
        fb.frame_end = is_end;
        frame_bytes_q.push_back(fb);
    endtask

    task automatic predict_frame_bytes(input t_item it);
        logic [LenW-1:0] wire_len;
        wire_len = it.payload_length + 16'd1;
        if (it.frame_start) begin
            push_frame_byte(SYNC_FIRST, 1'b0);
            push_frame_byte(SYNC_SECOND, 1'b0);
            push_frame_byte(wire_len[15:8], 1'b0);
            push_frame_byte(wire_len[7:0], 1'b0);
            push_frame_byte(it.command_code, 1'b0);
            sum_acc    = wire_len[15:8] + wire_len[7:0] + it.command_code;
            frame_open = 1'b1;
        end
        if (frame_open) begin
            if (it.has_byte) begin
                push_frame_byte(it.payload_byte, 1'b0);
                sum_acc = sum_acc + it.payload_byte;
            end
            if (it.frame_last) begin
                push_frame_byte(8'h00 - sum_acc, 1'b1);
                sum_acc    = '0;
                frame_open = 1'b0;
            end
        end
    endtask

    task automatic add_item(input logic start, input logic [7:0] code,
                            input logic [15:0] plen, input logic has,
                            input logic [7:0] data, input logic fin,
                            input t_idle_mode mode);
        t_stim s;
        s.item.frame_start    = start;
        s.item.command_code   = code;
        s.item.payload_length = plen;
        s.item.has_byte       = has;
        s.item.payload_byte   = data;
        s.item.frame_last     = fin;
        s.mode                = mode;
        item_q.push_back(s);
    endtask

    task automatic add_random_frame(input t_idle_mode mode);
        int unsigned n_mid;
        int unsigned n_bytes;
        logic        has0;
        logic        has_fin;
        logic        abandon;
        logic        fin_on_start;
        logic [15:0] plen;
        n_mid        = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
        has0         = $urandom_range(2) == 0;
        has_fin      = 1'($urandom_range(1));
        abandon      = $urandom_range(19) == 0;
        fin_on_start = (n_mid == 0) && ($urandom_range(2) == 0);
        n_bytes      = 32'(has0) + n_mid + (fin_on_start ? 32'd0 : 32'(has_fin));
        plen         = ($urandom_range(4) == 0) ? 16'($urandom_range(65535)) : 16'(n_bytes);
        add_item(1'b1, 8'($urandom), plen, has0, 8'($urandom),
                 fin_on_start && !abandon, mode);
        if (fin_on_start)
            return;
        for (int unsigned k = 0; k < n_mid; k++) begin
            add_item(1'b0, 8'($urandom), 16'($urandom), $urandom_range(9) != 0,
                     8'($urandom), 1'b0, mode);
        end
        if (!abandon)
            add_item(1'b0, 8'($urandom), 16'($urandom), has_fin, 8'($urandom), 1'b1, mode);
    endtask

    task automatic note_mismatch(input string what, input logic [8:0] exp_v,
                                 input logic [8:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReported)
            $display("mismatch (%s): expected end=%0d byte=%02h, got end=%0d byte=%02h",
                     what, exp_v[8], exp_v[7:0], act_v[8], act_v[7:0]);
    endtask

    // driver
    always @(posedge i_clk) begin : drive_items
        int unsigned idle_pct;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready)
                predict_frame_bytes(cur_item);
            if (!s_valid || o_s_axis_tready) begin
                idle_pct = 0;
                if (item_q.size() > 0) begin
                    case (item_q[0].mode)
                        IDLE_SEND: idle_pct = IdlePct;
                        IDLE_BOTH: idle_pct = LightIdlePct;
                        default:   idle_pct = 0;
                    endcase
                end
                if (item_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item = item_q[0].item;
                    case (item_q[0].mode)
                        IDLE_RECV: rx_stall_pct <= IdlePct;
                        IDLE_BOTH: rx_stall_pct <= LightIdlePct;
                        default:   rx_stall_pct <= 0;
                    endcase
                    void'(item_q.pop_front());
                    s_valid <= 1'b1;
                    s_tdata <= {cur_item.payload_byte, cur_item.payload_length,
                                cur_item.command_code};
                    s_tuser <= {cur_item.has_byte, cur_item.frame_start};
                    s_tlast <= cur_item.frame_last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_bytes
        t_frame_byte exp_b;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (frame_bytes_q.size() == 0) begin
                    note_mismatch("unexpected byte", 9'h0,
                                  {o_m_axis_tlast, o_m_axis_tdata});
                end else begin
                    exp_b = frame_bytes_q.pop_front();
                    if (exp_b.value !== o_m_axis_tdata || exp_b.frame_end !== o_m_axis_tlast)
                        note_mismatch("frame byte", {exp_b.frame_end, exp_b.value},
                                      {o_m_axis_tlast, o_m_axis_tdata});
                end
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog: cycles with work outstanding but no handshake on either side
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
                    || (item_q.size() == 0 && !s_valid && frame_bytes_q.size() == 0)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WatchdogMax) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_idle_mode mode;
        int unsigned base;

        // ignored while idle
        add_item(1'b0, 8'h12, 16'h0003, 1'b1, 8'h77, 1'b1, IDLE_NONE);
        // start and last together, empty payload
        add_item(1'b1, 8'h00, 16'h0000, 1'b0, 8'h00, 1'b1, IDLE_NONE);
        // length wraps to zero
        add_item(1'b1, 8'hFF, 16'hFFFF, 1'b0, 8'h00, 1'b0, IDLE_NONE);
        add_item(1'b0, 8'h00, 16'h0000, 1'b1, 8'hFF, 1'b0, IDLE_NONE);
        add_item(1'b0, 8'hFF, 16'hFFFF, 1'b1, 8'h00, 1'b0, IDLE_NONE);
        add_item(1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF, 1'b0, IDLE_NONE);
        add_item(1'b0, 8'h00, 16'h0000, 1'b1, 8'h80, 1'b1, IDLE_NONE);
        // largest legal length, then a new start abandons the frame
        add_item(1'b1, 8'hA5, 16'hFFFE, 1'b1, 8'h01, 1'b0, IDLE_NONE);
        add_item(1'b0, 8'h00, 16'h0000, 1'b1, 8'hFE, 1'b0, IDLE_NONE);
        add_item(1'b1, 8'h5A, 16'h0002, 1'b1, 8'h3C, 1'b0, IDLE_NONE);
        add_item(1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 1'b1, IDLE_NONE);
        // start, byte and last in one item
        add_item(1'b1, 8'h80, 16'h0001, 1'b1, 8'h55, 1'b1, IDLE_NONE);
        add_item(1'b0, 8'hFF, 16'hFFFF, 1'b0, 8'hFF, 1'b1, IDLE_NONE);
        add_item(1'b0, 8'hFF, 16'hFFFF, 1'b1, 8'hAA, 1'b0, IDLE_NONE);
        add_item(1'b1, 8'h01, 16'h00FF, 1'b0, 8'h00, 1'b0, IDLE_NONE);
        add_item(1'b0, 8'h00, 16'h0000, 1'b1, 8'h7F, 1'b1, IDLE_NONE);
        add_item(1'b1, 8'h7E, 16'h8000, 1'b1, 8'hFF, 1'b1, IDLE_NONE);

        base = item_q.size();
        while (item_q.size() - base < RandItems) begin
            if (item_q.size() - base < RandItems / 4)
                mode = IDLE_NONE;
            else if (item_q.size() - base < RandItems / 2)
                mode = IDLE_SEND;
            else if (item_q.size() - base < 3 * RandItems / 4)
                mode = IDLE_RECV;
            else
                mode = IDLE_BOTH;
            if ($urandom_range(6) == 0)
                add_item(1'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                         8'($urandom), 1'($urandom), mode);
            else
                add_random_frame(mode);
        end

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        while (item_q.size() > 0 || s_valid || frame_bytes_q.size() > 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatch_cnt == 0 && frame_bytes_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ command_frame_builder_top.f @@
rtl/cfb_pkg.sv
rtl/cfb_in_stage.sv
rtl/cfb_builder.sv
rtl/command_frame_builder_top.sv
verif/testbench.sv
